// ===== rtl/core/spl_pkg.sv =====
// Shared types and codes for the sorted priority list.
// No dependencies; spl_ctrl, spl_dp and the top level import this package.
`default_nettype none
package spl_pkg;

   localparam int SPL_DEPTH = 64;

   localparam logic [2:0] ACT_INSERT   = 3'd0;
   localparam logic [2:0] ACT_POP      = 3'd1;
   localparam logic [2:0] ACT_LOOKUP   = 3'd2;
   localparam logic [2:0] ACT_REMOVE   = 3'd3;
   localparam logic [2:0] ACT_PEEK_TOP = 3'd4;
   localparam logic [2:0] ACT_PEEK_BOT = 3'd5;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] key_value;
      logic [30:0] entry_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_value;
      logic [30:0] out_id;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/core/spl_chan_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; payload types come from spl_pkg at instantiation.
`default_nettype none
interface spl_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/spl_ctrl.sv =====
// Controller FSM: request capture, commit sequencing, response valid flag.
// Depends on spl_pkg.
`default_nettype none
module spl_ctrl
   import spl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_COMMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.commit  = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_ready);

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (cmd.commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_capture_then_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_COMMIT)
      else $error("capture not followed by commit state");

   a_commit_gives_word: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise response valid");

endmodule
`default_nettype wire

// ===== rtl/core/spl_dp.sv =====
// Datapath: row of value/id cells with per-cell compare, shift-in and
// shift-out, result selection and the response word register. Uses spl_pkg.
`default_nettype none
module spl_dp
   import spl_pkg::*;
#(
   parameter int DEPTH = SPL_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  req_type      req_word,
   output rsp_type      rsp_word
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [31:0]      val_ff [DEPTH];
   logic [31:0]      val_in [DEPTH];
   logic [30:0]      id_ff  [DEPTH];
   logic [30:0]      id_in  [DEPTH];
   logic [31:0]      prev_val [DEPTH];
   logic [30:0]      prev_id  [DEPTH];
   logic [31:0]      next_val [DEPTH];
   logic [30:0]      next_id  [DEPTH];
   logic [DEPTH-1:0] prev_ge;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       act_ff;
   logic [31:0]      key_ff;
   logic [30:0]      kid_ff;
   logic [DEPTH-1:0] ge_ff, ge_in, match_ff, match_in, last_ff, last_in;
   rsp_type          rsp_ff, rsp_in;

   logic             empty, full, found, do_insert, do_shift;
   logic [DEPTH-1:0] prefix, first_hot, sel_hot, shift_mask;
   logic [1:0]       status;
   logic [31:0]      sel_val;
   logic [30:0]      sel_id;
   logic [CNT_W+6:0] count_ext;

   // per-cell compares against the incoming word
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ge_in[i]    = (CNT_W'(i) < count_ff) && (val_ff[i] >= req_word.key_value);
         match_in[i] = (CNT_W'(i) < count_ff) && (id_ff[i] == req_word.entry_id);
         last_in[i]  = (CNT_W'(i + 1) == count_ff);
      end
   end

   // neighbor taps
   always_comb begin
      prev_val[0] = key_ff;
      prev_id[0]  = kid_ff;
      prev_ge[0]  = 1'b1;
      for (int i = 1; i < DEPTH; i++) begin
         prev_val[i] = val_ff[i-1];
         prev_id[i]  = id_ff[i-1];
         prev_ge[i]  = ge_ff[i-1];
      end
      next_val[DEPTH-1] = val_ff[DEPTH-1];
      next_id[DEPTH-1]  = id_ff[DEPTH-1];
      for (int i = 0; i < DEPTH - 1; i++) begin
         next_val[i] = val_ff[i+1];
         next_id[i]  = id_ff[i+1];
      end
   end

   always_comb begin
      empty = (count_ff == '0);
      full  = (count_ff == CNT_W'(DEPTH));
      found = |match_ff;

      // log-depth prefix OR: cells at or below the first match
      prefix = match_ff;
      for (int k = 1; k < DEPTH; k = k * 2) prefix = prefix | (prefix << k);
      first_hot = match_ff & ~(prefix << 1);

      status     = ST_DONE;
      sel_hot    = '0;
      do_insert  = 1'b0;
      do_shift   = 1'b0;
      shift_mask = '0;
      case (act_ff)
         ACT_INSERT: begin
            if (full) status = ST_FULL;
            else do_insert = 1'b1;
         end
         ACT_POP: begin
            if (empty) status = ST_EMPTY;
            else begin
               sel_hot    = DEPTH'(1);
               do_shift   = 1'b1;
               shift_mask = '1;
            end
         end
         ACT_PEEK_TOP: begin
            if (empty) status = ST_EMPTY;
            else sel_hot = DEPTH'(1);
         end
         ACT_PEEK_BOT: begin
            if (empty) status = ST_EMPTY;
            else sel_hot = last_ff;
         end
         ACT_LOOKUP: begin
            if (empty) status = ST_EMPTY;
            else if (!found) status = ST_NOT_FOUND;
            else sel_hot = first_hot;
         end
         ACT_REMOVE: begin
            if (empty) status = ST_EMPTY;
            else if (!found) status = ST_NOT_FOUND;
            else begin
               sel_hot    = first_hot;
               do_shift   = 1'b1;
               shift_mask = prefix;
            end
         end
         default: status = ST_DONE;
      endcase

      sel_val = '0;
      sel_id  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_val = sel_val | (sel_hot[i] ? val_ff[i] : 32'd0);
         sel_id  = sel_id  | (sel_hot[i] ? id_ff[i]  : 31'd0);
      end

      for (int i = 0; i < DEPTH; i++) begin
         val_in[i] = val_ff[i];
         id_in[i]  = id_ff[i];
         if (do_insert && !ge_ff[i]) begin
            val_in[i] = prev_ge[i] ? key_ff : prev_val[i];
            id_in[i]  = prev_ge[i] ? kid_ff : prev_id[i];
         end else if (do_shift && shift_mask[i]) begin
            val_in[i] = next_val[i];
            id_in[i]  = next_id[i];
         end
      end

      count_in = count_ff;
      if (do_insert) count_in = count_ff + CNT_W'(1);
      else if (do_shift) count_in = count_ff - CNT_W'(1);

      count_ext          = {7'd0, count_in};
      rsp_in.status      = status;
      rsp_in.out_value   = sel_val;
      rsp_in.out_id      = sel_id;
      rsp_in.entry_count = count_ext[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.commit) count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_word.action;
         key_ff   <= req_word.key_value;
         kid_ff   <= req_word.entry_id;
         ge_ff    <= ge_in;
         match_ff <= match_in;
         last_ff  <= last_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < DEPTH; i++) begin
            val_ff[i] <= val_in[i];
            id_ff[i]  <= id_in[i];
         end
      end
   end

   assign rsp_word = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && act_ff == ACT_INSERT && !full)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not add one entry");

endmodule
`default_nettype wire

// ===== rtl/core/sorted_priority_list_top.sv =====
// Top level of the sorted priority list: controller plus cell datapath.
// Depends on spl_pkg, spl_chan_if, spl_ctrl and spl_dp.
//
// Usage:
//   req_ch carries one request word (action, key_value, entry_id); rsp_ch
//   returns exactly one response word (status, out_value, out_id,
//   entry_count) per request, in order. A word moves when valid and ready
//   are both high at a rising clock edge.
//   Actions: insert, pop top, lookup by id, remove by id, peek top, peek
//   bottom. Entries stay ordered largest value first; equal values keep
//   arrival order.
//   A request passes the capture step, then the commit step; the next
//   request is taken only after its commit. Capture registers the per-cell
//   compares against the stored row; commit applies the shift across the
//   whole row, loads the response register and raises response valid.
//   If rsp_ready is low, one response waits in the output register; the
//   next request is still taken and then holds in the commit step until
//   the waiting word leaves, so req_ready stays low meanwhile.
//   Reset (synchronous, active high) empties the list by clearing the
//   entry count; no clearing pass is needed.
`default_nettype none
module sorted_priority_list_top
   import spl_pkg::*;
#(
   parameter int DEPTH = SPL_DEPTH
) (
   input logic        clock,
   input logic        reset,
   spl_chan_if.sink   req_ch,
   spl_chan_if.source rsp_ch
);

   ctrl_cmd_type cmd;
   rsp_type      rsp_word;
   logic         req_ready, rsp_valid;

   spl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   spl_dp #(.DEPTH(DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_ch.payload),
      .rsp_word (rsp_word)
   );

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_word;

endmodule
`default_nettype wire
